>>> rtl/tccs_pkg.sv
// shared constants, field layout and controller/datapath interface types
// for the text console cursor and scroll core; no dependencies
`default_nettype none

package tccs_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // field widths
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int LINES_W = 5;
    localparam int CELL_W  = ATTR_W + CHAR_W;

    // input tdata layout, lowest field first
    localparam int IN_CHAR_LSB  = 0;
    localparam int IN_ATTR_LSB  = IN_CHAR_LSB + CHAR_W;
    localparam int IN_COL_LSB   = IN_ATTR_LSB + ATTR_W;
    localparam int IN_ROW_LSB   = IN_COL_LSB + COL_W;
    localparam int IN_LINES_LSB = IN_ROW_LSB + ROW_W;
    localparam int IN_BITS      = IN_LINES_LSB + LINES_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest field first
    localparam int OUT_BITS   = COL_W + ROW_W + CHAR_W + ATTR_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // operation codes carried in tuser
    localparam logic [MODE_W-1:0] MODE_PRINT  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_PUT    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_SET    = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_SCROLL = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_READ   = MODE_W'(4);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] SPACE_CODE   = CHAR_W'(32);
    localparam logic [ATTR_W-1:0] RESET_ATTR   = ATTR_W'(15);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

    // linear cell address; the multiply is by a constant
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

    typedef struct packed {
        logic accept;       // input transaction taken this cycle
        logic clear_step;   // post-reset blanking, one cell
        logic exec;         // carry out the latched item
        logic scroll_step;  // one cell of a scroll pass
        logic post_write;   // cell write held back behind a scroll
        logic load_out;     // capture the result
    } tccs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_scroll;
        logic scroll_last;
        logic print_pending;
        logic out_free;
    } tccs_status_t;

endpackage

`default_nettype wire

>>> rtl/text_console_cursor_scroll_core.sv
// 80x25 text console core: one result per item; print, put, set cursor and read run an
// accept state and an execute state; the result is loaded at execute, or later if the output stalls.
// a scroll walks every cell once through the screen memory (one write port, one read port),
// then a drain state, plus a post-write state when a printed character lands on the new last row.
// one item in flight; the result register frees the input side. after reset a blanking
// pass over every cell runs before the first transaction is taken
`default_nettype none

module text_console_cursor_scroll_core
    import tccs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // character, attribute, column, row, line_count
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  wire logic [MODE_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // cursor_column, cursor_row, cell_character, cell_attribute
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [ATTR_W-1:0]     cfg_wr_data
);

    tccs_cmd_t    cmd;
    tccs_status_t status;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tccs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    // exec always follows an accept directly
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $past(s_tvalid && s_tready))
        else $error("exec without accepted transaction");

    // no input while the screen is still being blanked
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_tready)
        else $error("input ready during blanking pass");

    // reported cursor stays on screen or just past the last cell
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((32'(m_tdata[COL_W +: ROW_W]) < ROWS)
                   || ((32'(m_tdata[COL_W +: ROW_W]) == ROWS)
                    && (m_tdata[COL_W-1:0] == '0))))
        else $error("cursor out of range");

endmodule

`default_nettype wire

>>> rtl/tccs_ctrl.sv
// sequencing state machine for the text console core
// depends on tccs_pkg
`default_nettype none

module tccs_ctrl
    import tccs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire tccs_status_t status,
    output tccs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DRAIN,
        ST_PWRITE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last scroll write lands this cycle
                state_next = status.print_pending ? ST_PWRITE : ST_FINISH;
            end
            ST_PWRITE:
            begin
                cmd.post_write = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tccs_datapath.sv
// screen memory, cursor, scroll address generation and result register
// depends on tccs_pkg; driven by tccs_ctrl commands
`default_nettype none

module tccs_datapath
    import tccs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tccs_cmd_t             cmd,
    output tccs_status_t               status,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [MODE_W-1:0]     s_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [ATTR_W-1:0]     cfg_wr_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    // latched item
    logic [MODE_W-1:0]  mode_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [LINES_W-1:0] lines_reg;

    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ATTR_W-1:0] blank_attr_reg;

    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0] shift_reg;
    logic [ADDR_W-1:0] keep_end_reg;
    logic              pend_valid_reg;
    logic              pend_copy_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              print_pending_reg;

    logic [CELL_W-1:0]     rd_data_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // incoming fields for the early read
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic              in_inside;

    // decode of the latched item
    logic              item_inside;
    logic              is_nl;
    logic [ROW_W-1:0]  y1, y2;
    logic              pr_scroll;
    logic [COL_W-1:0]  x1, x2;
    logic [ROW_W-1:0]  lines_clamped;
    logic [ROW_W-1:0]  scroll_n;
    logic [ADDR_W-1:0] scroll_shift;
    logic              copy;
    logic              rd_ok;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign in_col    = s_tdata[IN_COL_LSB +: COL_W];
    assign in_row    = s_tdata[IN_ROW_LSB +: ROW_W];
    assign in_inside = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);

    assign item_inside = (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS);
    assign is_nl       = (char_reg == NEWLINE_CODE);
    assign y1          = cur_row_reg + ROW_W'(is_nl);
    assign pr_scroll   = (32'(y1) >= ROWS);
    assign y2          = pr_scroll ? LAST_ROW : y1;
    assign x1          = is_nl ? '0 : cur_col_reg;
    assign x2          = x1 + COL_W'(1);

    assign lines_clamped = (32'(lines_reg) > ROWS) ? ROW_W'(ROWS) : ROW_W'(lines_reg);
    assign scroll_n      = (mode_reg == MODE_PRINT) ? ROW_W'(1) : lines_clamped;
    assign scroll_shift  = cell_addr(scroll_n, '0);
    assign copy          = (dst_reg < keep_end_reg);
    assign rd_ok         = (mode_reg == MODE_READ) && item_inside;

    assign status.clear_last    = (dst_reg == LAST_CELL);
    assign status.scroll_last   = (dst_reg == LAST_CELL);
    assign status.need_scroll   = ((mode_reg == MODE_PRINT) && pr_scroll)
                                || ((mode_reg == MODE_SCROLL) && (lines_reg != '0));
    assign status.print_pending = print_pending_reg;
    assign status.out_free      = !m_tvalid_reg || m_tready;

    // cursor update, kept normalized: column below COLUMNS
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.exec)
        begin
            if (mode_reg == MODE_PRINT)
            begin
                if (is_nl)
                begin
                    cur_col_next = '0;
                    cur_row_next = y2;
                end
                else if (32'(x2) == COLUMNS)
                begin
                    cur_col_next = '0;
                    cur_row_next = y2 + ROW_W'(1);
                end
                else
                begin
                    cur_col_next = x2;
                    cur_row_next = y2;
                end
            end
            else if ((mode_reg == MODE_SET) && item_inside)
            begin
                cur_col_next = col_reg;
                cur_row_next = row_reg;
            end
        end
    end

    always_comb
    begin
        dst_next = dst_reg;
        if (cmd.exec)
        begin
            dst_next = '0;
        end
        else if (cmd.clear_step || cmd.scroll_step)
        begin
            dst_next = dst_reg + ADDR_W'(1);
        end
    end

    // single write port: blanking, delayed scroll writes, then cell writes
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = {RESET_ATTR, SPACE_CODE};
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_copy_reg ? rd_data_reg : {blank_attr_reg, SPACE_CODE};
        end
        else if (cmd.exec && (mode_reg == MODE_PRINT) && !is_nl && !pr_scroll)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(y2, x1);
            mem_wdata = {attr_reg, char_reg};
        end
        else if (cmd.exec && (mode_reg == MODE_PUT) && item_inside)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(row_reg, col_reg);
            mem_wdata = {attr_reg, char_reg};
        end
        else if (cmd.post_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(LAST_ROW, '0);
            mem_wdata = {attr_reg, char_reg};
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    // read issued on the accept cycle so the cell is ready for exec
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = dst_reg + shift_reg;
        priority if (cmd.accept && (s_tuser == MODE_READ) && in_inside)
        begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(in_row, in_col);
        end
        else if (cmd.scroll_step && copy)
        begin
            mem_re = 1'b1;
        end
        else
        begin
            mem_re = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= s_tuser;
            char_reg  <= s_tdata[IN_CHAR_LSB +: CHAR_W];
            attr_reg  <= s_tdata[IN_ATTR_LSB +: ATTR_W];
            col_reg   <= in_col;
            row_reg   <= in_row;
            lines_reg <= s_tdata[IN_LINES_LSB +: LINES_W];
        end
        if (cmd.exec)
        begin
            shift_reg    <= scroll_shift;
            keep_end_reg <= ADDR_W'(CELL_COUNT) - scroll_shift;
        end
        if (cmd.scroll_step)
        begin
            pend_copy_reg <= copy;
            pend_addr_reg <= dst_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_DATA_W'({rd_ok ? rd_data_reg : {CELL_W{1'b0}},
                                         cur_row_next, cur_col_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg       <= '0;
            cur_row_reg       <= '0;
            blank_attr_reg    <= RESET_ATTR;
            dst_reg           <= '0;
            pend_valid_reg    <= 1'b0;
            print_pending_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            dst_reg        <= dst_next;
            pend_valid_reg <= cmd.scroll_step;
            if (cfg_wr_en)
            begin
                blank_attr_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                print_pending_reg <= (mode_reg == MODE_PRINT) && !is_nl && pr_scroll;
            end
            else if (cmd.post_write)
            begin
                print_pending_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_text_console_cursor_scroll_core.sv
`timescale 1ns / 1ps
// testbench for text_console_cursor_scroll_core: a directed table with expected values, then
// random traffic in four idle/stall phases checked against a behavioral screen and cursor predictor
// depends on tccs_pkg and the core's rtl only

module tb_text_console_cursor_scroll_core
    import tccs_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int PHASE_ITEMS  = 282;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_READ + MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHAR_W-1:0]  ch;
        logic [ATTR_W-1:0]  attr;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [LINES_W-1:0] lines;
    } console_cmd_t;

    // msb first, so the packed value lines up with m_tdata
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
    } console_view_t;

    typedef struct {
        console_cmd_t  cmd;
        bit            typed;
        console_view_t view;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // character, attribute, column, row, line_count
    logic [MODE_W-1:0]     s_tuser = '0;   // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // cursor_column, cursor_row, cell_character,
                                           // cell_attribute
    logic                  cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]     cfg_wr_data = '0;

    // predictor state
    logic [CELL_W-1:0] screen_model [CELL_COUNT];
    int                cursor_pos;
    logic [ATTR_W-1:0] blank_attr;

    console_view_t view_q[$];
    script_row_t   script[$];
    int            mismatches = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;

    text_console_cursor_scroll_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void scroll_screen(input int lines);
        int n;
        n = (lines > ROWS) ? ROWS : lines;
        if (n == 0)
            return;
        for (int i = 0; i < (ROWS - n) * COLUMNS; i++)
            screen_model[i] = screen_model[i + n * COLUMNS];
        for (int i = (ROWS - n) * COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = {blank_attr, SPACE_CODE};
    endfunction

    function automatic console_view_t console_step(input console_cmd_t c);
        console_view_t v;
        int x;
        int y;
        int addr;
        bit in_range;
        in_range = (c.col < COLUMNS) && (c.row < ROWS);
        addr = int'(c.row) * COLUMNS + int'(c.col);
        v = '0;
        unique case (c.mode)
            MODE_PRINT:
            begin
                x = cursor_pos % COLUMNS;
                y = cursor_pos / COLUMNS;
                if (x >= COLUMNS || c.ch == NEWLINE_CODE)
                begin
                    x = 0;
                    y++;
                end
                // falling off the bottom scrolls one line and stays on the last row
                if (y >= ROWS)
                begin
                    scroll_screen(1);
                    y = ROWS - 1;
                end
                if (c.ch != NEWLINE_CODE)
                begin
                    screen_model[x + y * COLUMNS] = {c.attr, c.ch};
                    x++;
                end
                cursor_pos = x + y * COLUMNS;
            end
            MODE_PUT:
                if (in_range)
                    screen_model[addr] = {c.attr, c.ch};
            MODE_SET:
                if (in_range)
                    cursor_pos = addr;
            MODE_SCROLL:
                scroll_screen(int'(c.lines));
            MODE_READ:
                if (in_range)
                    {v.attr, v.ch} = screen_model[addr];
            default: ;
        endcase
        v.cur_col = COL_W'(cursor_pos % COLUMNS);
        v.cur_row = ROW_W'(cursor_pos / COLUMNS);
        return v;
    endfunction

    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        c.ch = CHAR_W'($urandom_range(255));
        c.attr = ATTR_W'($urandom_range(255));
        c.lines = LINES_W'($urandom_range(31));
        c.col = ($urandom_range(9) == 0) ? COL_W'($urandom_range(127))
                                         : COL_W'($urandom_range(COLUMNS - 1));
        // lean on the last row so prints reach the scroll path
        if ($urandom_range(9) == 0)
            c.row = ROW_W'($urandom_range(31));
        else if ($urandom_range(3) == 0)
            c.row = LAST_ROW;
        else
            c.row = ROW_W'($urandom_range(ROWS - 1));
        if (pick < 40)
        begin
            c.mode = MODE_PRINT;
            if ($urandom_range(7) == 0)
                c.ch = NEWLINE_CODE;
        end
        else if (pick < 55)
            c.mode = MODE_PUT;
        else if (pick < 67)
            c.mode = MODE_SET;
        else if (pick < 71)
            c.mode = MODE_SCROLL;
        else if (pick < 96)
            c.mode = MODE_READ;
        else
            c.mode = MODE_SPARE_FIRST
                   + MODE_W'($urandom_range(MODE_SPARE_LAST - MODE_SPARE_FIRST));
        return c;
    endfunction

    task automatic add_row(input int mode, input int ch, input int attr, input int col,
                           input int row, input int lines, input bit typed,
                           input int e_col, input int e_row, input int e_ch, input int e_attr);
        script_row_t r;
        r.cmd = '{MODE_W'(mode), CHAR_W'(ch), ATTR_W'(attr), COL_W'(col), ROW_W'(row),
                  LINES_W'(lines)};
        r.typed = typed;
        r.view = '{ATTR_W'(e_attr), CHAR_W'(e_ch), ROW_W'(e_row), COL_W'(e_col)};
        script.push_back(r);
    endtask

    // called at a clock edge; returns at the edge where the transaction is taken
    task automatic send_cmd(input console_cmd_t c, input bit typed, input console_view_t tv);
        console_view_t v;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.mode;
        s_tdata <= IN_DATA_W'({c.lines, c.row, c.col, c.attr, c.ch});
        do @(posedge clk); while (!s_tready);
        v = console_step(c);
        view_q.push_back(typed ? tv : v);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (view_q.size() != 0);
    endtask

    task automatic write_blank_attr(input logic [ATTR_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        blank_attr = value;
    endtask

    always @(posedge clk)
    begin : result_check
        console_view_t got;
        console_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = console_view_t'(m_tdata[OUT_BITS-1:0]);
            if (view_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transaction with none expected, data %h",
                             $realtime, m_tdata);
            end
            else
            begin
                want = view_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: exp/act col %0d/%0d row %0d/%0d char %h/%h attr %h/%h",
                                 $realtime,
                                 want.cur_col, got.cur_col, want.cur_row, got.cur_row,
                                 want.ch, got.ch, want.attr, got.attr);
                end
            end
        end
    end

    initial
    begin : stimulus
        for (int i = 0; i < CELL_COUNT; i++)
            screen_model[i] = {RESET_ATTR, SPACE_CODE};
        cursor_pos = 0;
        blank_attr = RESET_ATTR;

        // reset state, out-of-range positions, spare mode with every field at its top
        add_row(MODE_READ, 0, 0, 0, 0, 0, 1, 0, 0, SPACE_CODE, RESET_ATTR);
        add_row(MODE_READ, 0, 0, 79, 24, 0, 1, 0, 0, SPACE_CODE, RESET_ATTR);
        add_row(MODE_READ, 0, 0, 127, 31, 0, 1, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 80, 0, 0, 1, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 0, 25, 0, 1, 0, 0, 0, 0);
        add_row(MODE_SPARE_LAST, 255, 255, 127, 31, 31, 1, 0, 0, 0, 0);
        add_row(MODE_PRINT, 8'h41, 8'h07, 0, 0, 0, 1, 1, 0, 0, 0);
        add_row(MODE_PRINT, NEWLINE_CODE, 255, 0, 0, 0, 1, 0, 1, 0, 0);
        add_row(MODE_PUT, 255, 255, 79, 24, 0, 1, 0, 1, 0, 0);
        add_row(MODE_READ, 0, 0, 79, 24, 0, 1, 0, 1, 255, 255);
        add_row(MODE_PUT, 0, 0, 127, 31, 0, 1, 0, 1, 0, 0);
        add_row(MODE_SET, 0, 0, 80, 0, 0, 1, 0, 1, 0, 0);
        add_row(MODE_SET, 0, 0, 0, 25, 0, 1, 0, 1, 0, 0);
        add_row(MODE_SET, 0, 0, 79, 24, 0, 1, 79, 24, 0, 0);
        // last cell filled: cursor parks one past the end of the screen
        add_row(MODE_PRINT, 8'h5A, 8'h80, 0, 0, 0, 1, 0, 25, 0, 0);
        add_row(MODE_PRINT, 8'h71, 8'h1E, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 79, 23, 0, 0, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 0, 24, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_PRINT, NEWLINE_CODE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SCROLL, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(MODE_SCROLL, 0, 0, 0, 0, 24, 0, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SCROLL, 0, 0, 0, 0, 31, 0, 0, 0, 0, 0);
        add_row(MODE_READ, 0, 0, 79, 24, 0, 0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // let the post-reset blanking pass finish before touching the register
        do @(posedge clk); while (!s_tready);
        write_blank_attr(ATTR_W'(8'hA5));

        foreach (script[i])
            send_cmd(script[i].cmd, script[i].typed, script[i].view);

        for (int p = 0; p < 4; p++)
        begin
            write_blank_attr((p == 0) ? ATTR_W'(0) :
                             (p == 1) ? ATTR_W'(255) : ATTR_W'($urandom_range(255)));
            idle_pct = (p == 1) ? 47 : (p == 3) ? 7 : 0;
            stall_pct = (p == 2) ? 47 : (p == 3) ? 7 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 3)
                    drain_results();
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && view_q.size() == 0)
            $display("tb_text_console_cursor_scroll_core: PASS");
        else
            $display("tb_text_console_cursor_scroll_core: FAIL");
        $finish;
    end

    // every item scrolling and waiting on stalls still ends well inside this
    initial
    begin
        #(100_000_000);
        $display("tb_text_console_cursor_scroll_core: FAIL");
        $finish;
    end

endmodule
